/* sv/pgmd_pkg.sv */
// Package for the particle grid moment deposit block: widths, row and item
// types, saturating accumulate. No dependencies.
package pgmd_pkg;

  localparam int unsigned GRID_BITS_DEF = 5;
  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned GRID_BITS_MAX = 7;

  localparam int unsigned POS_W      = 21;
  localparam int unsigned CELL_IDX_W = 15;              // read_cell / cell_out
  localparam int unsigned CELL_MAX_W = 3 * GRID_BITS_MAX;
  localparam int unsigned OFF_W      = POS_W + 1;       // signed offset
  localparam int unsigned PROD_W     = 2 * OFF_W;       // signed product
  localparam int unsigned CNT_W      = 24;
  localparam int unsigned FIRST_W    = 40;
  localparam int unsigned SECOND_W   = 56;

  localparam int unsigned Q_DEPTH   = 4;   // front-to-back queue
  localparam int unsigned OUT_DEPTH = 4;   // result buffer

  typedef enum logic {
    REQ_DEPOSIT = 1'b0,
    REQ_READ    = 1'b1
  } req_e;

  // one cell row of the sum memory
  typedef struct packed {
    logic signed [CNT_W-1:0]    cnt;
    logic signed [FIRST_W-1:0]  sx;
    logic signed [FIRST_W-1:0]  sy;
    logic signed [FIRST_W-1:0]  sz;
    logic signed [SECOND_W-1:0] sxx;
    logic signed [SECOND_W-1:0] syy;
    logic signed [SECOND_W-1:0] szz;
    logic signed [SECOND_W-1:0] sxy;
    logic signed [SECOND_W-1:0] sxz;
    logic signed [SECOND_W-1:0] syz;
  } sums_t;

  // classified item; addr is sized for the largest grid, low bits used
  typedef struct packed {
    req_e                     req;
    logic                     neg;
    logic [CELL_MAX_W-1:0]    addr;
    logic signed [OFF_W-1:0]  dx;
    logic signed [OFF_W-1:0]  dy;
    logic signed [OFF_W-1:0]  dz;
    logic signed [PROD_W-1:0] dxx;
    logic signed [PROD_W-1:0] dyy;
    logic signed [PROD_W-1:0] dzz;
    logic signed [PROD_W-1:0] dxy;
    logic signed [PROD_W-1:0] dxz;
    logic signed [PROD_W-1:0] dyz;
  } dep_t;

  typedef struct packed {
    logic [CELL_IDX_W-1:0] cell_id;
    sums_t                 sums;
  } res_t;

  // acc +/- v, clamped to the signed range of w bits
  function automatic logic signed [SECOND_W-1:0] sat_acc(
    input logic signed [SECOND_W-1:0] acc,
    input logic signed [PROD_W-1:0]   v,
    input logic                       neg,
    input int unsigned                w
  );
    logic signed [SECOND_W+1:0] s;
    logic signed [SECOND_W+1:0] hi;
    logic signed [SECOND_W+1:0] lo;
    hi = ((SECOND_W+2)'(1) <<< (w - 1)) - (SECOND_W+2)'(1);
    lo = -hi - (SECOND_W+2)'(1);
    if (neg) begin
      s = (SECOND_W+2)'(acc) - (SECOND_W+2)'(v);
    end else begin
      s = (SECOND_W+2)'(acc) + (SECOND_W+2)'(v);
    end
    if (s > hi) begin
      s = hi;
    end else if (s < lo) begin
      s = lo;
    end
    return SECOND_W'(s);
  endfunction

endpackage

/* sv/pgmd_if.sv */
// Valid/ready channel interfaces for particle requests and cell results.
// Depends on pgmd_pkg.
interface pgmd_in_if;
  import pgmd_pkg::*;
  logic                  valid;
  logic                  ready;
  logic                  req_type;
  logic                  particle_sign;
  logic [POS_W-1:0]      pos_x;
  logic [POS_W-1:0]      pos_y;
  logic [POS_W-1:0]      pos_z;
  logic [CELL_IDX_W-1:0] read_cell;

  modport source (output valid, req_type, particle_sign, pos_x, pos_y, pos_z, read_cell,
                  input ready);
  modport sink (input valid, req_type, particle_sign, pos_x, pos_y, pos_z, read_cell,
                output ready);
endinterface

interface pgmd_out_if;
  import pgmd_pkg::*;
  logic                       valid;
  logic                       ready;
  logic [CELL_IDX_W-1:0]      cell_out;
  logic signed [CNT_W-1:0]    count_sum;
  logic signed [FIRST_W-1:0]  sum_dx;
  logic signed [FIRST_W-1:0]  sum_dy;
  logic signed [FIRST_W-1:0]  sum_dz;
  logic signed [SECOND_W-1:0] sum_dxx;
  logic signed [SECOND_W-1:0] sum_dyy;
  logic signed [SECOND_W-1:0] sum_dzz;
  logic signed [SECOND_W-1:0] sum_dxy;
  logic signed [SECOND_W-1:0] sum_dxz;
  logic signed [SECOND_W-1:0] sum_dyz;

  modport source (output valid, cell_out, count_sum, sum_dx, sum_dy, sum_dz, sum_dxx,
                  sum_dyy, sum_dzz, sum_dxy, sum_dxz, sum_dyz, input ready);
  modport sink (input valid, cell_out, count_sum, sum_dx, sum_dy, sum_dz, sum_dxx,
                sum_dyy, sum_dzz, sum_dxy, sum_dxz, sum_dyz, output ready);
endinterface

/* sv/pgmd_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Read and write to one address in the same cycle returns the old data.
module pgmd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

/* sv/pgmd_fifo.sv */
// Small register FIFO with valid/ready on both sides, used for the
// front-to-back queue and the result buffer. Depends on nothing.
module pgmd_fifo #(
  parameter type         T     = logic,
  parameter int unsigned DEPTH = 4
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  T     in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output T     out_data_o
);
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  T                 mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             push, pop;

  assign in_ready_o  = (cnt_q != CNT_W'(DEPTH));
  assign out_valid_o = (cnt_q != '0);
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;
  assign out_data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (push && !pop) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= in_data_i;
    end
  end
endmodule

/* sv/pgmd_front.sv */
// Front end: accepts requests, finds the cell and offsets (stage 1), forms
// the six offset products (stage 2) and feeds the queue. Depends on pgmd_pkg.
module pgmd_front #(
  parameter int unsigned GRID_BITS = pgmd_pkg::GRID_BITS_DEF,
  parameter int unsigned FRAC_BITS = pgmd_pkg::FRAC_BITS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          clr_busy_i,
  pgmd_in_if.sink       in_i,
  output logic          q_valid_o,
  input  logic          q_ready_i,
  output pgmd_pkg::dep_t q_item_o
);
  import pgmd_pkg::*;

  localparam int unsigned CELL_W   = 3 * GRID_BITS;
  localparam int unsigned GRID_MAX = (1 << GRID_BITS) - 1;

  function automatic logic [GRID_BITS-1:0] cell_of(input logic [POS_W-1:0] p);
    logic [POS_W:0] r;
    r = ({1'b0, p} + ((POS_W+1)'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
    if (r > (POS_W+1)'(GRID_MAX)) begin
      return GRID_BITS'(GRID_MAX);
    end
    return GRID_BITS'(r);
  endfunction

  function automatic logic signed [OFF_W-1:0] off_of(input logic [POS_W-1:0] p,
                                                      input logic [GRID_BITS-1:0] c);
    logic [POS_W+1:0] diff;
    diff = {2'b00, p} - ((POS_W+2)'(c) << FRAC_BITS);
    return OFF_W'(diff);
  endfunction

  logic                 en;
  logic                 s1_valid_q;
  logic                 s2_valid_q;
  dep_t                 s1_q;
  dep_t                 s2_q;
  dep_t                 s1_d;
  dep_t                 s2_d;
  logic [GRID_BITS-1:0] cx, cy, cz;

  // whole front moves together when stage 2 is empty or the queue can take its item
  assign en         = !s2_valid_q || q_ready_i;
  assign in_i.ready = !clr_busy_i && en;
  assign q_valid_o  = s2_valid_q;
  assign q_item_o   = s2_q;

  always_comb begin
    cx = cell_of(in_i.pos_x);
    cy = cell_of(in_i.pos_y);
    cz = cell_of(in_i.pos_z);
    s1_d      = '0;
    s1_d.req  = req_e'(in_i.req_type);
    s1_d.neg  = in_i.particle_sign;
    s1_d.dx   = off_of(in_i.pos_x, cx);
    s1_d.dy   = off_of(in_i.pos_y, cy);
    s1_d.dz   = off_of(in_i.pos_z, cz);
    if (s1_d.req == REQ_READ) begin
      s1_d.addr = CELL_MAX_W'(CELL_W'(in_i.read_cell));
    end else begin
      s1_d.addr = CELL_MAX_W'({cx, cy, cz});
    end
  end

  always_comb begin
    s2_d     = s1_q;
    s2_d.dxx = s1_q.dx * s1_q.dx;
    s2_d.dyy = s1_q.dy * s1_q.dy;
    s2_d.dzz = s1_q.dz * s1_q.dz;
    s2_d.dxy = s1_q.dx * s1_q.dy;
    s2_d.dxz = s1_q.dx * s1_q.dz;
    s2_d.dyz = s1_q.dy * s1_q.dz;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q <= in_i.valid && in_i.ready;
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_q <= s1_d;
      s2_q <= s2_d;
    end
  end
endmodule

/* sv/pgmd_back.sv */
// Back end: read-modify-write of cell rows in the sum memory with one-deep
// write forwarding, read-and-clear, and the clearing sweep after reset.
// Depends on pgmd_pkg and pgmd_ram.
module pgmd_back #(
  parameter int unsigned GRID_BITS = pgmd_pkg::GRID_BITS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_valid_i,
  output logic           q_ready_o,
  input  pgmd_pkg::dep_t q_item_i,
  input  logic           res_taken_i,
  output logic           res_valid_o,
  output pgmd_pkg::res_t res_o,
  output logic           clr_busy_o
);
  import pgmd_pkg::*;

  localparam int unsigned CELL_W = 3 * GRID_BITS;
  localparam int unsigned CELLS  = 1 << CELL_W;
  localparam int unsigned PEND_W = $clog2(OUT_DEPTH + 1);

  logic              clearing_q;
  logic [CELL_W-1:0] clr_q;
  logic [PEND_W-1:0] pend_q, pend_d;
  logic              issue;
  logic              b_valid_q;
  dep_t              b_item_q;
  logic [CELL_W-1:0] b_addr;
  logic              lw_valid_q;
  logic [CELL_W-1:0] lw_addr_q;
  sums_t             lw_data_q;
  sums_t             rdata, old_row, new_row, wdata;
  logic              we;
  logic [CELL_W-1:0] waddr;

  // a read is issued only with room reserved in the result buffer
  assign issue = !clearing_q && q_valid_i &&
                 ((q_item_i.req != REQ_READ) || (pend_q < PEND_W'(OUT_DEPTH)));
  assign q_ready_o  = issue;
  assign clr_busy_o = clearing_q;
  assign b_addr     = b_item_q.addr[CELL_W-1:0];

  always_comb begin
    pend_d = pend_q;
    if (issue && (q_item_i.req == REQ_READ)) begin
      pend_d = pend_d + PEND_W'(1);
    end
    if (res_taken_i) begin
      pend_d = pend_d - PEND_W'(1);
    end
  end

  pgmd_ram #(
    .WIDTH ($bits(sums_t)),
    .DEPTH (CELLS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (q_item_i.addr[CELL_W-1:0]),
    .rdata_o (rdata)
  );

  // the row written last cycle is not yet in the read data
  assign old_row = (lw_valid_q && (lw_addr_q == b_addr)) ? lw_data_q : rdata;

  always_comb begin
    new_row = '0;
    if (b_item_q.req == REQ_DEPOSIT) begin
      new_row.cnt = CNT_W'(sat_acc(SECOND_W'(old_row.cnt), PROD_W'(1), b_item_q.neg, CNT_W));
      new_row.sx  = FIRST_W'(sat_acc(SECOND_W'(old_row.sx), PROD_W'(b_item_q.dx),
                                     b_item_q.neg, FIRST_W));
      new_row.sy  = FIRST_W'(sat_acc(SECOND_W'(old_row.sy), PROD_W'(b_item_q.dy),
                                     b_item_q.neg, FIRST_W));
      new_row.sz  = FIRST_W'(sat_acc(SECOND_W'(old_row.sz), PROD_W'(b_item_q.dz),
                                     b_item_q.neg, FIRST_W));
      new_row.sxx = sat_acc(old_row.sxx, b_item_q.dxx, b_item_q.neg, SECOND_W);
      new_row.syy = sat_acc(old_row.syy, b_item_q.dyy, b_item_q.neg, SECOND_W);
      new_row.szz = sat_acc(old_row.szz, b_item_q.dzz, b_item_q.neg, SECOND_W);
      new_row.sxy = sat_acc(old_row.sxy, b_item_q.dxy, b_item_q.neg, SECOND_W);
      new_row.sxz = sat_acc(old_row.sxz, b_item_q.dxz, b_item_q.neg, SECOND_W);
      new_row.syz = sat_acc(old_row.syz, b_item_q.dyz, b_item_q.neg, SECOND_W);
    end
  end

  assign we    = clearing_q || b_valid_q;
  assign waddr = clearing_q ? clr_q : b_addr;
  assign wdata = clearing_q ? '0 : new_row;

  assign res_valid_o   = b_valid_q && (b_item_q.req == REQ_READ);
  assign res_o.cell_id = CELL_IDX_W'(b_addr);
  assign res_o.sums    = old_row;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_q      <= '0;
      pend_q     <= '0;
      b_valid_q  <= 1'b0;
      lw_valid_q <= 1'b0;
    end else begin
      if (clearing_q) begin
        clr_q <= clr_q + CELL_W'(1);
        if (clr_q == '1) begin
          clearing_q <= 1'b0;
        end
      end
      pend_q     <= pend_d;
      b_valid_q  <= issue;
      lw_valid_q <= b_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    b_item_q  <= q_item_i;
    lw_addr_q <= b_addr;
    lw_data_q <= new_row;
  end
endmodule

/* sv/particle_grid_moment_deposit_top.sv */
// Channel   Dir  Handshake     Payload
// in_i      in   valid/ready   req_type, particle_sign, pos_x/y/z, read_cell
// out_o     out  valid/ready   cell_out, count_sum, sum_d*, sum_d** (one per read)
//
// One item per cycle sustained, deposits and reads alike, unless reads stall
// as below; a read result passes the 2 front stages, the queue, the RAM read
// and update stage and the result buffer before it is on out_o.
// The rate is set by the read-modify-write on the cell memory,
// kept back to back by forwarding the row written in the previous cycle.
// After reset the memory is cleared one cell per cycle, all 2^(3*GRID_BITS)
// cells (32768 at the default), with in_i.ready low. Reads stall in the queue
// only while four results are outstanding (update stage plus the 4-entry
// result buffer). Depends on pgmd_pkg and all.
module particle_grid_moment_deposit_top #(
  parameter int unsigned GRID_BITS = pgmd_pkg::GRID_BITS_DEF,
  parameter int unsigned FRAC_BITS = pgmd_pkg::FRAC_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  pgmd_in_if.sink   in_i,
  pgmd_out_if.source out_o
);
  import pgmd_pkg::*;

  logic q_in_valid, q_in_ready;
  dep_t q_in_item;
  logic q_out_valid, q_out_ready;
  dep_t q_out_item;
  logic clr_busy;
  logic res_valid;
  res_t res, res_buf;

  pgmd_front #(
    .GRID_BITS (GRID_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .clr_busy_i (clr_busy),
    .in_i       (in_i),
    .q_valid_o  (q_in_valid),
    .q_ready_i  (q_in_ready),
    .q_item_o   (q_in_item)
  );

  pgmd_fifo #(
    .T     (dep_t),
    .DEPTH (Q_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (q_in_valid),
    .in_ready_o  (q_in_ready),
    .in_data_i   (q_in_item),
    .out_valid_o (q_out_valid),
    .out_ready_i (q_out_ready),
    .out_data_o  (q_out_item)
  );

  pgmd_back #(
    .GRID_BITS (GRID_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_out_valid),
    .q_ready_o   (q_out_ready),
    .q_item_i    (q_out_item),
    .res_taken_i (out_o.valid && out_o.ready),
    .res_valid_o (res_valid),
    .res_o       (res),
    .clr_busy_o  (clr_busy)
  );

  // space is reserved by the back end before a read issues
  pgmd_fifo #(
    .T     (res_t),
    .DEPTH (OUT_DEPTH)
  ) u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (res_valid),
    .in_ready_o  (),
    .in_data_i   (res),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_data_o  (res_buf)
  );

  assign out_o.cell_out  = res_buf.cell_id;
  assign out_o.count_sum = res_buf.sums.cnt;
  assign out_o.sum_dx    = res_buf.sums.sx;
  assign out_o.sum_dy    = res_buf.sums.sy;
  assign out_o.sum_dz    = res_buf.sums.sz;
  assign out_o.sum_dxx   = res_buf.sums.sxx;
  assign out_o.sum_dyy   = res_buf.sums.syy;
  assign out_o.sum_dzz   = res_buf.sums.szz;
  assign out_o.sum_dxy   = res_buf.sums.sxy;
  assign out_o.sum_dxz   = res_buf.sums.sxz;
  assign out_o.sum_dyz   = res_buf.sums.syz;
endmodule

/* sim/tb_particle_grid_moment_deposit_top.sv */
// Testbench for particle_grid_moment_deposit_top: directed rows, then random
// deposits and read-and-clear requests, checked against a cell-sum predictor.
// Depends on pgmd_pkg, pgmd_in_if/pgmd_out_if and the top module.
module tb_particle_grid_moment_deposit_top;
  timeunit 1ns;
  timeprecision 1ps;
  import pgmd_pkg::*;

  localparam int     GRID_N      = 1 << GRID_BITS_DEF;
  localparam int     CELLS       = 1 << (3 * GRID_BITS_DEF);
  localparam longint ONE         = longint'(1) << FRAC_BITS_DEF;
  localparam longint HALF        = ONE >> 1;
  localparam logic [POS_W-1:0] POS_MAX = '1;
  localparam longint EDGE_SQ     = 64'd4294836225;  // 65535^2
  localparam int     HOT_N       = 6;
  localparam int     CYCLE_LIMIT = 400000;
  localparam res_t   NO_WANT     = '0;

  typedef struct packed {
    req_e                  req;
    logic                  neg;
    logic [POS_W-1:0]      px;
    logic [POS_W-1:0]      py;
    logic [POS_W-1:0]      pz;
    logic [CELL_IDX_W-1:0] rcell;
    logic                  has_want;
    res_t                  want;
  } particle_req_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  pgmd_in_if  in_if ();
  pgmd_out_if out_if ();

  particle_grid_moment_deposit_top #(
    .GRID_BITS(GRID_BITS_DEF),
    .FRAC_BITS(FRAC_BITS_DEF)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  sums_t         cell_sums [CELLS];
  res_t          pending_results[$];
  particle_req_t directed_rows[$];
  int unsigned   hot_x [HOT_N];
  int unsigned   hot_y [HOT_N];
  int unsigned   hot_z [HOT_N];
  int unsigned   tx_calm;
  int unsigned   rx_calm;
  int unsigned   mismatches;
  int unsigned   cycle_count;
  bit            hold_results;

  function automatic longint clamp_sum(input longint acc, input longint delta,
                                       input int unsigned w);
    longint hi;
    longint lo;
    longint s;
    hi = (longint'(1) <<< (w - 1)) - 1;
    lo = -hi - 1;
    s = acc + delta;
    if (s > hi) s = hi;
    if (s < lo) s = lo;
    return s;
  endfunction

  // Applies one accepted item to the cell sums; returns 1 when it yields a result.
  function automatic bit update_moments(input particle_req_t r, output res_t rd);
    logic [POS_W-1:0] p [3];
    longint           c [3];
    longint           d [3];
    longint           v [10];
    int unsigned      idx;
    int               a;
    rd = '0;
    if (r.req == REQ_READ) begin
      idx = int'(r.rcell) & (CELLS - 1);
      rd.cell_id = CELL_IDX_W'(idx);
      rd.sums = cell_sums[idx];
      cell_sums[idx] = '0;
      return 1'b1;
    end
    p[0] = r.px;
    p[1] = r.py;
    p[2] = r.pz;
    for (a = 0; a < 3; a++) begin
      c[a] = (longint'(p[a]) + HALF) >>> FRAC_BITS_DEF;
      // rounding up past the last cell lands in the last cell
      if (c[a] > longint'(GRID_N - 1)) c[a] = longint'(GRID_N - 1);
      d[a] = longint'(p[a]) - (c[a] <<< FRAC_BITS_DEF);
    end
    idx = int'((c[0] << (2 * GRID_BITS_DEF)) | (c[1] << GRID_BITS_DEF) | c[2]);
    v = '{1, d[0], d[1], d[2], d[0] * d[0], d[1] * d[1], d[2] * d[2],
          d[0] * d[1], d[0] * d[2], d[1] * d[2]};
    if (r.neg) begin
      foreach (v[k]) v[k] = -v[k];
    end
    cell_sums[idx].cnt = CNT_W'(clamp_sum(cell_sums[idx].cnt, v[0], CNT_W));
    cell_sums[idx].sx  = FIRST_W'(clamp_sum(cell_sums[idx].sx, v[1], FIRST_W));
    cell_sums[idx].sy  = FIRST_W'(clamp_sum(cell_sums[idx].sy, v[2], FIRST_W));
    cell_sums[idx].sz  = FIRST_W'(clamp_sum(cell_sums[idx].sz, v[3], FIRST_W));
    cell_sums[idx].sxx = SECOND_W'(clamp_sum(cell_sums[idx].sxx, v[4], SECOND_W));
    cell_sums[idx].syy = SECOND_W'(clamp_sum(cell_sums[idx].syy, v[5], SECOND_W));
    cell_sums[idx].szz = SECOND_W'(clamp_sum(cell_sums[idx].szz, v[6], SECOND_W));
    cell_sums[idx].sxy = SECOND_W'(clamp_sum(cell_sums[idx].sxy, v[7], SECOND_W));
    cell_sums[idx].sxz = SECOND_W'(clamp_sum(cell_sums[idx].sxz, v[8], SECOND_W));
    cell_sums[idx].syz = SECOND_W'(clamp_sum(cell_sums[idx].syz, v[9], SECOND_W));
    return 1'b0;
  endfunction

  function automatic res_t cell_result(input int unsigned cell_id,
                                       input longint cnt, sx, sy, sz,
                                       input longint sxx, syy, szz, sxy, sxz, syz);
    res_t r;
    r.cell_id  = CELL_IDX_W'(cell_id);
    r.sums.cnt = CNT_W'(cnt);
    r.sums.sx  = FIRST_W'(sx);
    r.sums.sy  = FIRST_W'(sy);
    r.sums.sz  = FIRST_W'(sz);
    r.sums.sxx = SECOND_W'(sxx);
    r.sums.syy = SECOND_W'(syy);
    r.sums.szz = SECOND_W'(szz);
    r.sums.sxy = SECOND_W'(sxy);
    r.sums.sxz = SECOND_W'(sxz);
    r.sums.syz = SECOND_W'(syz);
    return r;
  endfunction

  // mostly random gaps, with runs of back-to-back items now and then
  function automatic int unsigned draw_gap(inout int unsigned calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 18);
  endfunction

  function automatic void pick_hot_cells();
    for (int h = 0; h < HOT_N; h++) begin
      hot_x[h] = $urandom_range(0, GRID_N - 1);
      hot_y[h] = $urandom_range(0, GRID_N - 1);
      hot_z[h] = $urandom_range(0, GRID_N - 1);
    end
  endfunction

  // position near the center of cell c, sometimes noise or an extreme
  function automatic logic [POS_W-1:0] axis_pos(input int unsigned c);
    int          p;
    int unsigned pick;
    int unsigned span;
    pick = $urandom_range(0, 19);
    if (pick == 0) return POS_W'($urandom);
    if (pick == 1) return '0;
    if (pick == 2) return POS_MAX;
    span = (c == GRID_N - 1) ? int'(ONE + HALF - 1) : int'(ONE - 1);
    p = int'(c) * int'(ONE) - int'(HALF) + int'($urandom_range(0, span));
    if (p < 0) p = 0;
    return POS_W'(p);
  endfunction

  function automatic particle_req_t random_req(input int unsigned read_pct);
    particle_req_t r;
    int unsigned   h;
    r       = '0;
    r.neg   = ($urandom_range(0, 9) < 3);
    r.px    = POS_W'($urandom);
    r.py    = POS_W'($urandom);
    r.pz    = POS_W'($urandom);
    r.rcell = CELL_IDX_W'($urandom);
    h = $urandom_range(0, HOT_N - 1);
    if ($urandom_range(0, 99) < read_pct) begin
      r.req = REQ_READ;
      if ($urandom_range(0, 3) != 0) begin
        r.rcell = CELL_IDX_W'((hot_x[h] << (2 * GRID_BITS_DEF)) |
                              (hot_y[h] << GRID_BITS_DEF) | hot_z[h]);
      end
    end else begin
      r.req = REQ_DEPOSIT;
      r.px  = axis_pos(hot_x[h]);
      r.py  = axis_pos(hot_y[h]);
      r.pz  = axis_pos(hot_z[h]);
    end
    return r;
  endfunction

  task automatic send_req(input particle_req_t r, input int unsigned gap);
    res_t rd;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid         <= 1'b1;
    in_if.req_type      <= r.req;
    in_if.particle_sign <= r.neg;
    in_if.pos_x         <= r.px;
    in_if.pos_y         <= r.py;
    in_if.pos_z         <= r.pz;
    in_if.read_cell     <= r.rcell;
    do @(posedge clk_i); while (!in_if.ready);
    if (update_moments(r, rd)) begin
      pending_results = {pending_results, (r.has_want ? r.want : rd)};
    end
  endtask

  function automatic void check_field(input int unsigned cell_id, input string name,
                                      input longint want, input longint got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("cell %0d %s: expected %0d, got %0d", cell_id, name, want, got);
      end
    end
  endfunction

  // result side
  initial begin
    res_t        want;
    int unsigned gap;
    out_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if (hold_results) begin
        hold_results = 1'b0;
        gap = 100;
      end else begin
        gap = draw_gap(rx_calm);
      end
      if (gap > 0) begin
        out_if.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (!out_if.valid);
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("result for cell %0d with nothing outstanding", out_if.cell_out);
        end
      end else begin
        want = pending_results.pop_front();
        check_field(want.cell_id, "cell_out", want.cell_id, out_if.cell_out);
        check_field(want.cell_id, "count_sum", want.sums.cnt, out_if.count_sum);
        check_field(want.cell_id, "sum_dx", want.sums.sx, out_if.sum_dx);
        check_field(want.cell_id, "sum_dy", want.sums.sy, out_if.sum_dy);
        check_field(want.cell_id, "sum_dz", want.sums.sz, out_if.sum_dz);
        check_field(want.cell_id, "sum_dxx", want.sums.sxx, out_if.sum_dxx);
        check_field(want.cell_id, "sum_dyy", want.sums.syy, out_if.sum_dyy);
        check_field(want.cell_id, "sum_dzz", want.sums.szz, out_if.sum_dzz);
        check_field(want.cell_id, "sum_dxy", want.sums.sxy, out_if.sum_dxy);
        check_field(want.cell_id, "sum_dxz", want.sums.sxz, out_if.sum_dxz);
        check_field(want.cell_id, "sum_dyz", want.sums.syz, out_if.sum_dyz);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_particle_grid_moment_deposit_top failed");
      $finish;
    end
  end

  // request side
  initial begin
    rst_ni              <= 1'b0;
    in_if.valid         <= 1'b0;
    in_if.req_type      <= REQ_DEPOSIT;
    in_if.particle_sign <= 1'b0;
    in_if.pos_x         <= '0;
    in_if.pos_y         <= '0;
    in_if.pos_z         <= '0;
    in_if.read_cell     <= '0;
    foreach (cell_sums[i]) cell_sums[i] = '0;

    // req, neg, x, y, z, read_cell, has_want, typed-in result
    directed_rows = '{
      // fresh cells read as zero; sign and position ignored on reads
      '{REQ_READ, 1'b1, POS_MAX, POS_MAX, POS_MAX, 15'd0, 1'b1,
        cell_result(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0)},
      '{REQ_READ, 1'b0, 21'h0AAAAA, 21'h155555, 21'h000001, 15'h7FFF, 1'b1,
        cell_result(32767, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0)},
      '{REQ_DEPOSIT, 1'b0, 21'd0, 21'd0, 21'd0, 15'h7FFF, 1'b0, NO_WANT},
      '{REQ_READ, 1'b0, 21'd0, 21'd0, 21'd0, 15'd0, 1'b1,
        cell_result(0, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0)},
      // top edge on all three axes
      '{REQ_DEPOSIT, 1'b0, POS_MAX, POS_MAX, POS_MAX, 15'h2AAA, 1'b0, NO_WANT},
      '{REQ_READ, 1'b0, 21'd0, 21'd0, 21'd0, 15'h7FFF, 1'b1,
        cell_result(32767, 1, 65535, 65535, 65535,
                    EDGE_SQ, EDGE_SQ, EDGE_SQ, EDGE_SQ, EDGE_SQ, EDGE_SQ)},
      '{REQ_DEPOSIT, 1'b1, POS_MAX, POS_MAX, POS_MAX, 15'h5555, 1'b0, NO_WANT},
      '{REQ_DEPOSIT, 1'b1, POS_MAX, POS_MAX, POS_MAX, 15'h0000, 1'b0, NO_WANT},
      '{REQ_READ, 1'b1, 21'd0, 21'd0, 21'd0, 15'h7FFF, 1'b1,
        cell_result(32767, -2, -131070, -131070, -131070,
                    -2 * EDGE_SQ, -2 * EDGE_SQ, -2 * EDGE_SQ,
                    -2 * EDGE_SQ, -2 * EDGE_SQ, -2 * EDGE_SQ)},
      // exactly half a cell rounds up, just below rounds down
      '{REQ_DEPOSIT, 1'b0, 21'h008000, 21'h007FFF, 21'd0, 15'h1234, 1'b0, NO_WANT},
      '{REQ_READ, 1'b0, 21'd0, 21'd0, 21'd0, 15'd1024, 1'b1,
        cell_result(1024, 1, -32768, 32767, 0,
                    1073741824, 1073676289, 0, -1073709056, 0, 0)},
      '{REQ_DEPOSIT, 1'b0, 21'h1F7FFF, 21'h010000, 21'h1F8000, 15'h0F0F, 1'b0, NO_WANT},
      '{REQ_DEPOSIT, 1'b1, 21'd1, 21'd2, 21'd3, 15'h7000, 1'b0, NO_WANT},
      '{REQ_DEPOSIT, 1'b0, 21'h155555, 21'h0AAAAA, POS_MAX, 15'h00FF, 1'b0, NO_WANT},
      '{REQ_DEPOSIT, 1'b0, 21'h0AAAAA, 21'h155555, 21'd0, 15'h3C3C, 1'b0, NO_WANT},
      '{REQ_READ, 1'b0, POS_MAX, 21'd0, POS_MAX, 15'd31807, 1'b0, NO_WANT},
      '{REQ_READ, 1'b1, 21'd0, POS_MAX, 21'd0, 15'd21887, 1'b0, NO_WANT},
      '{REQ_READ, 1'b0, 21'd0, 21'd0, 21'd0, 15'd11936, 1'b0, NO_WANT},
      '{REQ_READ, 1'b0, 21'd0, 21'd0, 21'd0, 15'd0, 1'b0, NO_WANT},
      // a read clears the cell
      '{REQ_READ, 1'b0, 21'd0, 21'd0, 21'd0, 15'd0, 1'b1,
        cell_result(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0)}
    };

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i]) send_req(directed_rows[i], draw_gap(tx_calm));

    pick_hot_cells();
    repeat (250) send_req(random_req(30), draw_gap(tx_calm));

    // drain fully, then flood reads while the result side is held off
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
    hold_results = 1'b1;
    repeat (40) send_req(random_req(80), 0);

    pick_hot_cells();
    repeat (260) send_req(random_req(30), draw_gap(tx_calm));
    in_if.valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb_particle_grid_moment_deposit_top passed");
    end else begin
      $display("tb_particle_grid_moment_deposit_top failed");
    end
    $finish;
  end

endmodule
